// ===== hdl/cpu_block0_register_ops_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef CPU_BLOCK0_REGISTER_OPS_ASSERT_SVH
`define CPU_BLOCK0_REGISTER_OPS_ASSERT_SVH

// Antecedent implies consequent in the same cycle, ignored while in reset.
`define CBRO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, ignored while in reset.
`define CBRO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked during reset too.
`define CBRO_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cbro_pkg.sv =====
`timescale 1ns / 1ps

package cbro_pkg;

    // Architectural register file.
    typedef struct packed {
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
    } t_regs;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Instruction groups, opcode bits 2:0.
    localparam logic [2:0] GRP_CTRL     = 3'd0;
    localparam logic [2:0] GRP_R16      = 3'd1;
    localparam logic [2:0] GRP_MEM      = 3'd2;
    localparam logic [2:0] GRP_INCDEC16 = 3'd3;
    localparam logic [2:0] GRP_INC8     = 3'd4;
    localparam logic [2:0] GRP_DEC8     = 3'd5;
    localparam logic [2:0] GRP_LD8      = 3'd6;
    localparam logic [2:0] GRP_ACC      = 3'd7;

    // Select codes for the control group.
    localparam logic [2:0] SEL_NOP = 3'd0;

    // 8-bit register select codes, opcode bits 5:3.
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // 16-bit register pair codes, opcode bits 5:4.
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // Accumulator and flag operations, opcode bits 5:3 of the last group.
    localparam logic [2:0] ACC_RLCA = 3'd0;
    localparam logic [2:0] ACC_RRCA = 3'd1;
    localparam logic [2:0] ACC_RLA  = 3'd2;
    localparam logic [2:0] ACC_RRA  = 3'd3;
    localparam logic [2:0] ACC_DAA  = 3'd4;
    localparam logic [2:0] ACC_CPL  = 3'd5;
    localparam logic [2:0] ACC_SCF  = 3'd6;
    localparam logic [2:0] ACC_CCF  = 3'd7;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] BCD_MAX    = 8'h99;
    localparam logic [3:0] DIGIT_MAX  = 4'h9;

    function automatic logic [7:0] get_r8(input t_regs regs, input logic [2:0] sel);
        logic [7:0] v;
        unique case (sel)
            REG_B:   v = regs.b;
            REG_C:   v = regs.c;
            REG_D:   v = regs.d;
            REG_E:   v = regs.e;
            REG_H:   v = regs.h;
            REG_L:   v = regs.l;
            REG_A:   v = regs.acc;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_regs put_r8(input t_regs regs, input logic [2:0] sel,
                                     input logic [7:0] v);
        t_regs r;
        r = regs;
        unique case (sel)
            REG_B:   r.b = v;
            REG_C:   r.c = v;
            REG_D:   r.d = v;
            REG_E:   r.e = v;
            REG_H:   r.h = v;
            REG_L:   r.l = v;
            REG_A:   r.acc = v;
            default: r = regs;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] get_r16(input t_regs regs, input logic [1:0] p);
        logic [15:0] v;
        unique case (p)
            PAIR_BC: v = {regs.b, regs.c};
            PAIR_DE: v = {regs.d, regs.e};
            PAIR_HL: v = {regs.h, regs.l};
            PAIR_SP: v = regs.sp;
        endcase
        return v;
    endfunction

    function automatic t_regs put_r16(input t_regs regs, input logic [1:0] p,
                                      input logic [15:0] v);
        t_regs r;
        r = regs;
        unique case (p)
            PAIR_BC: {r.b, r.c} = v;
            PAIR_DE: {r.d, r.e} = v;
            PAIR_HL: {r.h, r.l} = v;
            PAIR_SP: r.sp = v;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/cpu_block0_register_ops.sv =====
// Register-only instructions of opcode block 0x00-0x3F of an 8-bit CPU.
// The input channel (i_in_valid / o_in_ready) carries one instruction per
// transfer: a 6-bit opcode and a 16-bit immediate. The output channel
// (o_out_valid / i_out_ready) carries one result per instruction: the done
// flag, A, the Z/N/H/C flags, BC, DE, HL and SP as they stand after it.
// Opcodes that touch memory, jump, stop or store SP leave every register
// unchanged and report done as zero.
// An instruction in the input register executes into the result register
// when the result slot is free or is being emptied, and the result is then
// offered. The sustained rate is one instruction per cycle while the result
// is taken; it is set by the register file update, which reads and writes
// the whole file at once so that each instruction sees the one before it.
// When the receiver stalls, the result holds, the executed register file
// holds with it, and one more instruction waits in the input register;
// o_in_ready drops only when that register is full and the result is not
// being taken.
// Reset (i_rst_n low at a rising edge) clears all registers and flags to
// zero and empties both stages.
`timescale 1ns / 1ps

module cpu_block0_register_ops
    import cbro_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_opcode,
    input  logic [15:0] i_immediate,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_done_res,
    output logic [7:0]  o_acc_out,
    output logic [3:0]  o_flags_out,
    output logic [15:0] o_pair_bc,
    output logic [15:0] o_pair_de,
    output logic [15:0] o_pair_hl,
    output logic [15:0] o_stack_ptr
);

    // Input stage: the accepted instruction waits here for execution.
    logic        r_in_valid;
    logic [5:0]  r_op;
    logic [15:0] r_imm;

    // Result stage: the register file itself doubles as the result payload,
    // since it only changes when a new result is loaded.
    logic        r_out_valid;
    logic        r_done;
    t_regs       r_st;

    logic        n_done;
    t_regs       n_st;

    logic        exec;
    logic [2:0]  grp;
    logic [2:0]  sel;
    logic [1:0]  pair;
    logic [7:0]  v8;
    logic [7:0]  v8_inc;
    logic [7:0]  v8_dec;
    logic [15:0] r16;
    logic [15:0] hl;
    logic [16:0] hl_sum;
    logic [12:0] hl_sum_lo;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_res;

    // An instruction executes when one is waiting and the result slot is
    // free or is being emptied in this cycle.
    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;

    assign grp  = r_op[2:0];
    assign sel  = r_op[5:3];
    assign pair = r_op[5:4];

    always_comb begin
        v8        = get_r8(r_st, sel);
        v8_inc    = v8 + 8'd1;
        v8_dec    = v8 - 8'd1;
        r16       = get_r16(r_st, pair);
        hl        = {r_st.h, r_st.l};
        hl_sum    = {1'b0, hl} + {1'b0, r16};
        hl_sum_lo = {1'b0, hl[11:0]} + {1'b0, r16[11:0]};

        // Decimal adjust: after a subtraction only the recorded half and
        // full carries drive the correction; after an addition an
        // out-of-range digit does as well.
        if (r_st.flags[FLAG_N]) begin
            daa_lo = r_st.flags[FLAG_H];
            daa_hi = r_st.flags[FLAG_C];
        end else begin
            daa_lo = r_st.flags[FLAG_H] || (r_st.acc[3:0] > DIGIT_MAX);
            daa_hi = r_st.flags[FLAG_C] || (r_st.acc > BCD_MAX);
        end
        daa_adj = (daa_lo ? DAA_LO_ADJ : 8'h00) | (daa_hi ? DAA_HI_ADJ : 8'h00);
        daa_res = r_st.flags[FLAG_N] ? (r_st.acc - daa_adj) : (r_st.acc + daa_adj);

        n_st   = r_st;
        n_done = 1'b1;

        unique case (grp)
            GRP_CTRL: begin
                n_done = (sel == SEL_NOP);
            end
            GRP_R16: begin
                if (!sel[0]) begin
                    n_st = put_r16(r_st, pair, r_imm);
                end else begin
                    {n_st.h, n_st.l}   = hl_sum[15:0];
                    n_st.flags[FLAG_N] = 1'b0;
                    n_st.flags[FLAG_H] = hl_sum_lo[12];
                    n_st.flags[FLAG_C] = hl_sum[16];
                end
            end
            GRP_MEM: begin
                n_done = 1'b0;
            end
            GRP_INCDEC16: begin
                n_st = put_r16(r_st, pair, sel[0] ? (r16 - 16'd1) : (r16 + 16'd1));
            end
            GRP_INC8: begin
                if (sel == REG_MEM) begin
                    n_done = 1'b0;
                end else begin
                    n_st               = put_r8(r_st, sel, v8_inc);
                    n_st.flags[FLAG_Z] = (v8_inc == 8'h00);
                    n_st.flags[FLAG_N] = 1'b0;
                    n_st.flags[FLAG_H] = (v8[3:0] == 4'hF);
                end
            end
            GRP_DEC8: begin
                if (sel == REG_MEM) begin
                    n_done = 1'b0;
                end else begin
                    n_st               = put_r8(r_st, sel, v8_dec);
                    n_st.flags[FLAG_Z] = (v8_dec == 8'h00);
                    n_st.flags[FLAG_N] = 1'b1;
                    n_st.flags[FLAG_H] = (v8[3:0] == 4'h0);
                end
            end
            GRP_LD8: begin
                if (sel == REG_MEM) begin
                    n_done = 1'b0;
                end else begin
                    n_st = put_r8(r_st, sel, r_imm[7:0]);
                end
            end
            GRP_ACC: begin
                unique case (sel)
                    ACC_RLCA: begin
                        n_st.acc   = {r_st.acc[6:0], r_st.acc[7]};
                        n_st.flags = {3'b000, r_st.acc[7]};
                    end
                    ACC_RRCA: begin
                        n_st.acc   = {r_st.acc[0], r_st.acc[7:1]};
                        n_st.flags = {3'b000, r_st.acc[0]};
                    end
                    ACC_RLA: begin
                        n_st.acc   = {r_st.acc[6:0], r_st.flags[FLAG_C]};
                        n_st.flags = {3'b000, r_st.acc[7]};
                    end
                    ACC_RRA: begin
                        n_st.acc   = {r_st.flags[FLAG_C], r_st.acc[7:1]};
                        n_st.flags = {3'b000, r_st.acc[0]};
                    end
                    ACC_DAA: begin
                        n_st.acc           = daa_res;
                        n_st.flags[FLAG_Z] = (daa_res == 8'h00);
                        n_st.flags[FLAG_H] = 1'b0;
                        n_st.flags[FLAG_C] = daa_hi;
                    end
                    ACC_CPL: begin
                        n_st.acc           = ~r_st.acc;
                        n_st.flags[FLAG_N] = 1'b1;
                        n_st.flags[FLAG_H] = 1'b1;
                    end
                    ACC_SCF: begin
                        n_st.flags = {r_st.flags[FLAG_Z], 3'b001};
                    end
                    ACC_CCF: begin
                        n_st.flags = {r_st.flags[FLAG_Z], 2'b00, ~r_st.flags[FLAG_C]};
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op  <= i_opcode;
            r_imm <= i_immediate;
        end
        if (exec) begin
            r_done <= n_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_done_res  = r_done;
    assign o_acc_out   = r_st.acc;
    assign o_flags_out = r_st.flags;
    assign o_pair_bc   = {r_st.b, r_st.c};
    assign o_pair_de   = {r_st.d, r_st.e};
    assign o_pair_hl   = {r_st.h, r_st.l};
    assign o_stack_ptr = r_st.sp;

endmodule

// ===== hdl/cbro_checker.sv =====
`timescale 1ns / 1ps
`include "cpu_block0_register_ops_assert.svh"

module cbro_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [5:0]  i_opcode,
    input logic [15:0] i_immediate,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_done_res,
    input logic [7:0]  o_acc_out,
    input logic [3:0]  o_flags_out,
    input logic [15:0] o_pair_bc,
    input logic [15:0] o_pair_de,
    input logic [15:0] o_pair_hl,
    input logic [15:0] o_stack_ptr
);

    // A result stays offered until it is taken.
    `CBRO_ASSERT_NXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result withdrawn before transfer")

    // A stalled result keeps its payload.
    `CBRO_ASSERT_NXT(a_out_payload_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_done_res) && $stable(o_acc_out) && $stable(o_flags_out) && $stable(o_pair_bc) && $stable(o_pair_de) && $stable(o_pair_hl) && $stable(o_stack_ptr), "stalled result changed")

    // Reset empties both stages: no result is offered and input is accepted.
    `CBRO_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready, "pipeline not empty after reset")

    // A newly offered result always has a matching earlier instruction transfer.
    `CBRO_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2), "result without a matching instruction transfer")

endmodule

bind cpu_block0_register_ops cbro_checker u_cbro_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for cpu_block0_register_ops.
//
// The sender and the receiver each run their own process. The sender drives
// instructions on the falling clock edge and watches for the transfer on the
// rising edge. At that edge it also steps its own copy of the register file
// and queues the result it expects. The receiver side samples every result
// transfer on the rising edge and checks it field by field against the
// oldest queued expectation.
//
// The stimulus has two parts. A short directed table comes first. It covers
// reset values, the ignored opcodes, 16-bit wrap-around, the half carry and
// carry of ADD HL, and every accumulator and flag operation. Rows whose
// result is obvious carry a typed-in expectation. All other rows use the
// predictor. Random instructions follow, weighted toward the accumulator
// group and toward loads of corner values. This way the half-carry, zero
// and decimal adjust paths see interesting operands often.
module tb_top;
    import cbro_pkg::*;

    // One result as it appears on the output channel.
    typedef struct packed {
        logic        done;
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
    } result_t;

    // One row of the directed table. When typed is set, want holds the
    // result written out by hand. Otherwise the predictor supplies it.
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] imm;
        bit          typed;
        result_t     want;
    } plan_row_t;

    // The package does not name the select codes of the ignored control
    // and memory opcodes, so they are named here.
    localparam logic [2:0] SEL_STORE_SP = 3'd1;
    localparam logic [2:0] SEL_STOP     = 3'd2;
    localparam logic [2:0] SEL_JR_C     = 3'd7;
    localparam logic [2:0] SEL_ST_BC    = 3'd0;

    localparam int RANDOM_ITEMS   = 680;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [5:0]  i_opcode    = '0;
    logic [15:0] i_immediate = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_done_res;
    logic [7:0]  o_acc_out;
    logic [3:0]  o_flags_out;
    logic [15:0] o_pair_bc;
    logic [15:0] o_pair_de;
    logic [15:0] o_pair_hl;
    logic [15:0] o_stack_ptr;

    // These hold the predicted register file, the results still to arrive,
    // and the directed table.
    t_regs     cpu_state;
    result_t   pending_results[$];
    plan_row_t directed_rows[$];

    int n_fail       = 0;
    int n_results    = 0;
    int seen_results = 0;
    int ready_wait   = 0;
    int idle_cycles  = 0;

    cpu_block0_register_ops dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_immediate (i_immediate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_done_res  (o_done_res),
        .o_acc_out   (o_acc_out),
        .o_flags_out (o_flags_out),
        .o_pair_bc   (o_pair_bc),
        .o_pair_de   (o_pair_de),
        .o_pair_hl   (o_pair_hl),
        .o_stack_ptr (o_stack_ptr)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // This draws the wait before the next transfer. Every fourth stretch of
    // forty transfers runs with no waits, so back-to-back traffic gets
    // exercised as well.
    function automatic int pick_wait(input int k);
        if ((k / 40) % 4 == 1)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [15:0] pair_of(input t_regs s, input logic [1:0] p);
        case (p)
            PAIR_BC: return {s.b, s.c};
            PAIR_DE: return {s.d, s.e};
            PAIR_HL: return {s.h, s.l};
            default: return s.sp;
        endcase
    endfunction

    function automatic t_regs with_pair(input t_regs s, input logic [1:0] p,
                                        input logic [15:0] v);
        t_regs r;
        r = s;
        case (p)
            PAIR_BC: {r.b, r.c} = v;
            PAIR_DE: {r.d, r.e} = v;
            PAIR_HL: {r.h, r.l} = v;
            default: r.sp = v;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] reg8_of(input t_regs s, input logic [2:0] sel);
        case (sel)
            REG_B:   return s.b;
            REG_C:   return s.c;
            REG_D:   return s.d;
            REG_E:   return s.e;
            REG_H:   return s.h;
            REG_L:   return s.l;
            default: return s.acc;
        endcase
    endfunction

    function automatic t_regs with_reg8(input t_regs s, input logic [2:0] sel,
                                        input logic [7:0] v);
        t_regs r;
        r = s;
        case (sel)
            REG_B:   r.b = v;
            REG_C:   r.c = v;
            REG_D:   r.d = v;
            REG_E:   r.e = v;
            REG_H:   r.h = v;
            REG_L:   r.l = v;
            default: r.acc = v;
        endcase
        return r;
    endfunction

    // This executes one instruction on a copy of the register file and
    // returns the new file. done is cleared for the opcodes that the block
    // ignores, and those leave the file untouched.
    function automatic t_regs execute_instr(input t_regs s, input logic [5:0] op,
                                            input logic [15:0] imm, output bit done);
        logic [2:0]  grp;
        logic [2:0]  sel;
        logic [1:0]  pr;
        logic [3:0]  f;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  adj;
        logic        cin;
        logic [15:0] hl;
        logic [15:0] r16;
        logic [16:0] sum;
        logic [12:0] half;
        grp  = op[2:0];
        sel  = op[5:3];
        pr   = sel[2:1];
        f    = s.flags;
        done = 1'b1;
        case (grp)
            GRP_CTRL: done = (sel == SEL_NOP);
            GRP_R16: begin
                if (!sel[0]) begin
                    s = with_pair(s, pr, imm);
                end else begin
                    // The ADD HL half carry comes out of bit 11 and the
                    // carry out of bit 15. Z is kept.
                    hl   = pair_of(s, PAIR_HL);
                    r16  = pair_of(s, pr);
                    sum  = {1'b0, hl} + {1'b0, r16};
                    half = {1'b0, hl[11:0]} + {1'b0, r16[11:0]};
                    f[FLAG_H] = half[12];
                    f[FLAG_C] = sum[16];
                    f[FLAG_N] = 1'b0;
                    s.flags   = f;
                    s = with_pair(s, PAIR_HL, sum[15:0]);
                end
            end
            GRP_MEM: done = 1'b0;
            GRP_INCDEC16: begin
                if (sel[0])
                    s = with_pair(s, pr, pair_of(s, pr) - 16'd1);
                else
                    s = with_pair(s, pr, pair_of(s, pr) + 16'd1);
            end
            GRP_INC8, GRP_DEC8: begin
                if (sel == REG_MEM) begin
                    done = 1'b0;
                end else begin
                    // C is left alone by the 8-bit increment and decrement.
                    v = reg8_of(s, sel);
                    if (grp == GRP_INC8) begin
                        f[FLAG_N] = 1'b0;
                        f[FLAG_H] = (v[3:0] == 4'hF);
                        v = v + 8'd1;
                    end else begin
                        f[FLAG_N] = 1'b1;
                        f[FLAG_H] = (v[3:0] == 4'h0);
                        v = v - 8'd1;
                    end
                    f[FLAG_Z] = (v == 8'h00);
                    s = with_reg8(s, sel, v);
                    s.flags = f;
                end
            end
            GRP_LD8: begin
                if (sel == REG_MEM)
                    done = 1'b0;
                else
                    s = with_reg8(s, sel, imm[7:0]);
            end
            default: begin
                a   = s.acc;
                cin = f[FLAG_C];
                case (sel)
                    ACC_RLCA: begin
                        s.acc = {a[6:0], a[7]};
                        f = '0;
                        f[FLAG_C] = a[7];
                    end
                    ACC_RRCA: begin
                        s.acc = {a[0], a[7:1]};
                        f = '0;
                        f[FLAG_C] = a[0];
                    end
                    ACC_RLA: begin
                        s.acc = {a[6:0], cin};
                        f = '0;
                        f[FLAG_C] = a[7];
                    end
                    ACC_RRA: begin
                        s.acc = {cin, a[7:1]};
                        f = '0;
                        f[FLAG_C] = a[0];
                    end
                    ACC_DAA: begin
                        // After a subtraction only the pending corrections
                        // are taken away, and C stays as it was. After an
                        // addition the digits are checked against the BCD
                        // limits, and the high correction sets C.
                        adj = '0;
                        if (f[FLAG_N]) begin
                            if (f[FLAG_H])
                                adj = adj + DAA_LO_ADJ;
                            if (f[FLAG_C])
                                adj = adj + DAA_HI_ADJ;
                            a = a - adj;
                        end else begin
                            if (f[FLAG_H] || a[3:0] > DIGIT_MAX)
                                adj = adj + DAA_LO_ADJ;
                            if (f[FLAG_C] || a > BCD_MAX) begin
                                adj = adj + DAA_HI_ADJ;
                                f[FLAG_C] = 1'b1;
                            end
                            a = a + adj;
                        end
                        s.acc = a;
                        f[FLAG_Z] = (a == 8'h00);
                        f[FLAG_H] = 1'b0;
                    end
                    ACC_CPL: begin
                        s.acc = ~a;
                        f[FLAG_N] = 1'b1;
                        f[FLAG_H] = 1'b1;
                    end
                    ACC_SCF: begin
                        f[FLAG_N] = 1'b0;
                        f[FLAG_H] = 1'b0;
                        f[FLAG_C] = 1'b1;
                    end
                    default: begin
                        f[FLAG_N] = 1'b0;
                        f[FLAG_H] = 1'b0;
                        f[FLAG_C] = ~f[FLAG_C];
                    end
                endcase
                s.flags = f;
            end
        endcase
        return s;
    endfunction

    function automatic result_t regs_view(input logic done, input logic [7:0] acc,
                                          input logic [3:0] flags, input logic [15:0] bc,
                                          input logic [15:0] de, input logic [15:0] hl,
                                          input logic [15:0] sp);
        result_t r;
        r.done  = done;
        r.acc   = acc;
        r.flags = flags;
        r.bc    = bc;
        r.de    = de;
        r.hl    = hl;
        r.sp    = sp;
        return r;
    endfunction

    task automatic add_row(input logic [5:0] op, input logic [15:0] imm, input bit typed,
                           input result_t want);
        plan_row_t row;
        row.op    = op;
        row.imm   = imm;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // This offers one instruction and waits for its transfer. The task is
    // entered and left just after a falling edge. After a zero wait, valid
    // stays high with the new payload. After a nonzero wait, it drops for
    // that many cycles first.
    task automatic send_instr(input logic [5:0] op, input logic [15:0] imm, input bit typed,
                              input result_t want, output bit done);
        int      gap;
        result_t predicted;
        gap = pick_wait(pending_results.size() + n_results);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_immediate <= imm;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        cpu_state = execute_instr(cpu_state, op, imm, done);
        predicted = regs_view(done, cpu_state.acc, cpu_state.flags,
                              pair_of(cpu_state, PAIR_BC), pair_of(cpu_state, PAIR_DE),
                              pair_of(cpu_state, PAIR_HL), cpu_state.sp);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // This checks each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_fail++;
                $display("%0t: result transfer with no instruction pending", $time);
            end else begin
                want = pending_results.pop_front();
                check_field("done_res", 16'(want.done), 16'(o_done_res));
                check_field("acc_out", 16'(want.acc), 16'(o_acc_out));
                check_field("flags_out", 16'(want.flags), 16'(o_flags_out));
                check_field("pair_bc", want.bc, o_pair_bc);
                check_field("pair_de", want.de, o_pair_de);
                check_field("pair_hl", want.hl, o_pair_hl);
                check_field("stack_ptr", want.sp, o_stack_ptr);
            end
        end
    end

    // The receiver holds ready low for a freshly drawn number of cycles
    // after each result transfer. A count that changed since the last
    // falling edge means the previous result was just taken.
    always @(negedge i_clk) begin
        if (n_results != seen_results) begin
            seen_results = n_results;
            ready_wait   = pick_wait(n_results);
        end
        if (ready_wait > 0) begin
            ready_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // The watchdog ends the run if neither channel has had a transfer for
    // too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        result_t   none;
        bit        done;
        int        executed;
        logic [5:0]  op;
        logic [15:0] imm;
        none      = '0;
        cpu_state = '0;
        executed  = 0;

        // The first rows run on the cleared register file, so every result
        // up to the load of SP can be written out by hand.
        add_row({SEL_NOP, GRP_CTRL}, 16'h0000, 1'b1,
                regs_view(1'b1, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({SEL_STORE_SP, GRP_CTRL}, 16'hFFFF, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({SEL_STOP, GRP_CTRL}, 16'hFFFF, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({REG_MEM, GRP_LD8}, 16'h00FF, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({REG_MEM, GRP_INC8}, 16'h0000, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({SEL_ST_BC, GRP_MEM}, 16'h0000, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({SEL_JR_C, GRP_CTRL}, 16'h00FF, 1'b1,
                regs_view(1'b0, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({PAIR_BC, 1'b0, GRP_R16}, 16'hFFFF, 1'b1,
                regs_view(1'b1, 8'h00, 4'h0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        add_row({PAIR_BC, 1'b0, GRP_INCDEC16}, 16'h0000, 1'b1,
                regs_view(1'b1, 8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row({PAIR_BC, 1'b1, GRP_INCDEC16}, 16'h0000, 1'b1,
                regs_view(1'b1, 8'h00, 4'h0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        add_row({PAIR_SP, 1'b0, GRP_R16}, 16'hFFFF, 1'b1,
                regs_view(1'b1, 8'h00, 4'h0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        // ADD HL,SP with both operands at the limits carries out of bit 11
        // and out of bit 15. The load of A takes only the low byte.
        add_row({PAIR_HL, 1'b0, GRP_R16}, 16'h0FFF, 1'b0, none);
        add_row({PAIR_SP, 1'b1, GRP_R16}, 16'h0000, 1'b0, none);
        add_row({REG_A, GRP_LD8}, 16'h12FF, 1'b0, none);
        add_row({REG_A, GRP_INC8}, 16'h0000, 1'b0, none);
        add_row({REG_A, GRP_DEC8}, 16'h0000, 1'b0, none);
        add_row({ACC_RLCA, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_RRCA, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_RLA, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_RRA, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_CPL, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_DAA, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_SCF, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({ACC_CCF, GRP_ACC}, 16'h0000, 1'b0, none);
        add_row({REG_MEM, GRP_DEC8}, 16'hFFFF, 1'b0, none);

        // Reset is held low and then released on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_instr(directed_rows[k].op, directed_rows[k].imm, directed_rows[k].typed,
                       directed_rows[k].want, done);

        // In the random part, at least a quarter of the instructions are
        // accumulator and flag operations, and at least an eighth are loads, so
        // that the registers keep picking up corner values. Ignored opcodes are
        // sent too but do not count toward the total.
        while (executed < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0, 1: op = {3'($urandom_range(0, 7)), GRP_ACC};
                2: begin
                    if ($urandom_range(0, 1))
                        op = {3'($urandom_range(0, 7)), GRP_LD8};
                    else
                        op = {2'($urandom_range(0, 3)), 1'b0, GRP_R16};
                end
                default: op = 6'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 11))
                    0:       imm = 16'h0000;
                    1:       imm = 16'hFFFF;
                    2:       imm = 16'h0FFF;
                    3:       imm = 16'hF000;
                    4:       imm = 16'h000F;
                    5:       imm = 16'h0010;
                    6:       imm = 16'h0099;
                    7:       imm = 16'h009A;
                    8:       imm = 16'h00F0;
                    9:       imm = 16'h8000;
                    10:      imm = 16'h7FFF;
                    default: imm = 16'h0001;
                endcase
            end else begin
                imm = 16'($urandom);
            end
            send_instr(op, imm, 1'b0, none, done);
            if (done)
                executed++;
        end
        i_in_valid <= 1'b0;

        // The loop waits until every expected result has been taken. A settling
        // wait then lets any stray extra result show up.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cbro_pkg.sv
hdl/cpu_block0_register_ops.sv
hdl/cbro_checker.sv
tb/tb_top.sv
